// ===== design/gcd_pkg.sv =====
// shared constants, types and functions for the great circle distance pipeline
package gcd_pkg;

    localparam int ANGLE_BITS        = 32;
    localparam int CORDIC_ITERATIONS = 28;
    localparam int QF                = 30;
    localparam int XW                = 34;
    localparam int ZW                = 34;
    localparam int RADIUS_W          = 24;

    typedef logic signed [XW-1:0] t_xy;
    typedef logic signed [ZW-1:0] t_z;

    typedef struct packed {
        logic neg;
        t_z   z;
    } t_fold;

    localparam t_xy GAIN_Q30 = t_xy'(652032874);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6371009);

    localparam t_z QUARTER_Z = t_z'(1) <<< (ANGLE_BITS - 2);
    localparam t_z HALF_Z    = t_z'(1) <<< (ANGLE_BITS - 1);

    localparam logic signed [31:0] LAT_LIM = 32'sh4000_0000;

    localparam logic signed [2*XW-1:0] RND_Q = (2*XW)'(1) <<< (QF - 1);

    // pi/4 in Q62 from the Machin series
    function automatic logic [63:0] pi4_q62();
        logic [63:0] p;
        logic [63:0] s5;
        logic [63:0] s239;
        logic [63:0] t;
        p  = (64'd1 << 62) / 64'd5;
        s5 = '0;
        for (int k = 0; k < 40; k++) begin
            if (p != 0) begin
                t = p / 64'(2 * k + 1);
                if ((k % 2) == 0) s5 = s5 + t;
                else s5 = s5 - t;
                p = p / 64'd25;
            end
        end
        p    = (64'd1 << 62) / 64'd239;
        s239 = '0;
        for (int k = 0; k < 40; k++) begin
            if (p != 0) begin
                t = p / 64'(2 * k + 1);
                if ((k % 2) == 0) s239 = s239 + t;
                else s239 = s239 - t;
                p = p / 64'd57121;
            end
        end
        return (s5 << 2) - s239;
    endfunction

    // atan(2^-i) in angle units, rounded to nearest
    function automatic logic [31:0] atan_entry(input int i);
        logic [63:0] pi4;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] t;
        logic [31:0] q;
        pi4 = pi4_q62();
        if (i == 0) begin
            return 32'd1 << (ANGLE_BITS - 3);
        end
        p = 64'd1 << (62 - i);
        r = '0;
        for (int k = 0; k < 40; k++) begin
            if (p != 0) begin
                t = p / 64'(2 * k + 1);
                if ((k % 2) == 0) r = r + t;
                else r = r - t;
                p = p >> (2 * i);
            end
        end
        q = '0;
        for (int j = 0; j < ANGLE_BITS - 3; j++) begin
            r = r << 1;
            q = q << 1;
            if (r >= pi4) begin
                r    = r - pi4;
                q[0] = 1'b1;
            end
        end
        r = r << 1;
        if (r >= pi4) q = q + 32'd1;
        return q;
    endfunction

    // Q30 product, rounded half up
    function automatic t_xy mulq(input t_xy a, input t_xy b);
        logic signed [2*XW-1:0] pr;
        pr = a * b;
        pr = pr + RND_Q;
        return XW'(pr >>> QF);
    endfunction

    function automatic logic [31:0] clamp_lat(input logic signed [31:0] v);
        if (v > LAT_LIM) return LAT_LIM;
        if (v < -LAT_LIM) return -LAT_LIM;
        return v;
    endfunction

    // fold into +-quarter turn for the rotation
    function automatic t_fold fold_angle(input logic [31:0] ang);
        t_fold f;
        t_z    zs;
        zs    = t_z'($signed(ang));
        f.neg = 1'b0;
        if (zs > QUARTER_Z) begin
            zs    = zs - HALF_Z;
            f.neg = 1'b1;
        end else if (zs < -QUARTER_Z) begin
            zs    = zs + HALF_Z;
            f.neg = 1'b1;
        end
        f.z = zs;
        return f;
    endfunction

endpackage

// ===== design/great_circle_distance.sv =====
// great circle distance pipeline: cordic sin/cos, products, two vectoring passes, scaling
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | i_valid / o_stall   | i_lat_a, i_lon_a, i_lat_b, i_lon_b
//  out     | output    | o_valid / i_stall   | o_distance_m, o_central_angle
//  cfg     | input     | i_cfg_we            | i_cfg_wdata (sphere radius, metres)
//
//  one transfer per cycle sustained while i_stall is low
//  the three chains of cordic stages hold one stage per iteration
//  a one-entry input skid keeps o_stall a register; the whole pipe holds on output stall
//  synchronous active-low reset clears valid bits and loads the default radius
module great_circle_distance #(
    parameter int CORDIC_ITERATIONS = gcd_pkg::CORDIC_ITERATIONS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [31:0]             i_lat_a,
    input  logic signed [31:0]             i_lon_a,
    input  logic signed [31:0]             i_lat_b,
    input  logic signed [31:0]             i_lon_b,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [25:0]                    o_distance_m,
    output logic [31:0]                    o_central_angle,
    input  logic                           i_cfg_we,
    input  logic [gcd_pkg::RADIUS_W-1:0]   i_cfg_wdata
);

    localparam int N      = CORDIC_ITERATIONS;
    localparam int STAGES = 3 * N + 10;
    localparam int XW     = gcd_pkg::XW;
    localparam int ZW     = gcd_pkg::ZW;

    localparam logic [63:0] TWO_PI_Q60 = gcd_pkg::pi4_q62() << 1;
    localparam logic [31:0] B_LO = TWO_PI_Q60[31:0];
    localparam logic [31:0] B_HI = TWO_PI_Q60[63:32];
    localparam logic [119:0] RND_D = 120'(1) << 91;

    logic [gcd_pkg::RADIUS_W-1:0] r_radius;
    logic [STAGES-1:0]            r_vld;
    logic                         w_adv;

    // input skid
    logic               r_skid_v;
    logic signed [31:0] r_skid_lat_a, r_skid_lon_a, r_skid_lat_b, r_skid_lon_b;
    logic               w_src_v;
    logic signed [31:0] w_lat_a, w_lon_a, w_lat_b, w_lon_b;
    logic [31:0]        w_ang [0:2];
    gcd_pkg::t_fold     w_fold [0:2];

    // rotation lanes: lat_a, lat_b, longitude difference
    gcd_pkg::t_xy r_rx   [0:N][0:2];
    gcd_pkg::t_xy r_ry   [0:N][0:2];
    gcd_pkg::t_z  r_rz   [0:N][0:2];
    logic         r_rneg [0:N][0:2];

    gcd_pkg::t_xy r_s [0:2];
    gcd_pkg::t_xy r_c [0:2];

    gcd_pkg::t_xy r_y1, r_t1, r_t2, r_t3, r_t4, r_cd;
    gcd_pkg::t_xy w_y2, w_b;

    gcd_pkg::t_xy r_vx [0:N];
    gcd_pkg::t_xy r_vy [0:N];
    gcd_pkg::t_xy r_vb [0:N];

    gcd_pkg::t_xy r_m, r_mb, w_m;

    gcd_pkg::t_xy r_wx [0:N];
    gcd_pkg::t_xy r_wy [0:N];
    gcd_pkg::t_z  r_wz [0:N];

    logic [31:0]  r_ang_cl, r_ang_d1, r_ang_d2, r_ang_out;
    logic [55:0]  r_prod_a;
    logic [63:0]  r_p00, r_p01;
    logic [55:0]  r_p10, r_p11;
    logic [119:0] w_sum;
    logic [25:0]  r_dist;

    assign w_adv   = !(r_vld[STAGES-1] && i_stall);
    assign o_stall = r_skid_v;
    assign o_valid = r_vld[STAGES-1];
    assign o_distance_m    = r_dist;
    assign o_central_angle = r_ang_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcd_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_adv) r_skid_v <= 1'b0;
        end else if (i_valid && !w_adv) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && i_valid && !w_adv) begin
            r_skid_lat_a <= i_lat_a;
            r_skid_lon_a <= i_lon_a;
            r_skid_lat_b <= i_lat_b;
            r_skid_lon_b <= i_lon_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[STAGES-2:0], w_src_v};
        end
    end

    always_comb begin
        w_src_v = r_skid_v || i_valid;
        w_lat_a = r_skid_v ? r_skid_lat_a : i_lat_a;
        w_lon_a = r_skid_v ? r_skid_lon_a : i_lon_a;
        w_lat_b = r_skid_v ? r_skid_lat_b : i_lat_b;
        w_lon_b = r_skid_v ? r_skid_lon_b : i_lon_b;
        w_ang[0] = gcd_pkg::clamp_lat(w_lat_a);
        w_ang[1] = gcd_pkg::clamp_lat(w_lat_b);
        w_ang[2] = w_lon_b - w_lon_a;
        for (int l = 0; l < 3; l++) begin
            w_fold[l] = gcd_pkg::fold_angle(w_ang[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_rx[0][l]   <= gcd_pkg::GAIN_Q30;
                r_ry[0][l]   <= '0;
                r_rz[0][l]   <= w_fold[l].z;
                r_rneg[0][l] <= w_fold[l].neg;
            end
        end
    end

    // rotation mode, one iteration per stage
    for (genvar g = 0; g < N; g++) begin : g_rot
        localparam gcd_pkg::t_z ATN = ZW'(gcd_pkg::atan_entry(g));
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int l = 0; l < 3; l++) begin
                    if (r_rz[g][l][ZW-1]) begin
                        r_rx[g+1][l] <= r_rx[g][l] + (r_ry[g][l] >>> g);
                        r_ry[g+1][l] <= r_ry[g][l] - (r_rx[g][l] >>> g);
                        r_rz[g+1][l] <= r_rz[g][l] + ATN;
                    end else begin
                        r_rx[g+1][l] <= r_rx[g][l] - (r_ry[g][l] >>> g);
                        r_ry[g+1][l] <= r_ry[g][l] + (r_rx[g][l] >>> g);
                        r_rz[g+1][l] <= r_rz[g][l] - ATN;
                    end
                    r_rneg[g+1][l] <= r_rneg[g][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < 3; l++) begin
                r_s[l] <= r_rneg[N][l] ? -r_ry[N][l] : r_ry[N][l];
                r_c[l] <= r_rneg[N][l] ? -r_rx[N][l] : r_rx[N][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_y1 <= gcd_pkg::mulq(r_c[1], r_s[2]);
            r_t1 <= gcd_pkg::mulq(r_c[0], r_s[1]);
            r_t2 <= gcd_pkg::mulq(r_s[0], r_c[1]);
            r_t3 <= gcd_pkg::mulq(r_s[0], r_s[1]);
            r_t4 <= gcd_pkg::mulq(r_c[0], r_c[1]);
            r_cd <= r_c[2];
        end
    end

    always_comb begin
        w_y2 = r_t1 - gcd_pkg::mulq(r_t2, r_cd);
        w_b  = r_t3 + gcd_pkg::mulq(r_t4, r_cd);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vx[0] <= r_y1[XW-1] ? -r_y1 : r_y1;
            r_vy[0] <= w_y2[XW-1] ? -w_y2 : w_y2;
            r_vb[0] <= w_b;
        end
    end

    // vectoring for the magnitude
    for (genvar g = 0; g < N; g++) begin : g_vec1
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (!r_vy[g][XW-1] && (r_vy[g] != '0)) begin
                    r_vx[g+1] <= r_vx[g] + (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] - (r_vx[g] >>> g);
                end else begin
                    r_vx[g+1] <= r_vx[g] - (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] + (r_vx[g] >>> g);
                end
                r_vb[g+1] <= r_vb[g];
            end
        end
    end

    assign w_m = gcd_pkg::mulq(r_vx[N], gcd_pkg::GAIN_Q30);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m  <= w_m[XW-1] ? '0 : w_m;
            r_mb <= r_vb[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_mb[XW-1]) begin
                r_wx[0] <= r_m;
                r_wy[0] <= -r_mb;
                r_wz[0] <= gcd_pkg::QUARTER_Z;
            end else begin
                r_wx[0] <= r_mb;
                r_wy[0] <= r_m;
                r_wz[0] <= '0;
            end
        end
    end

    // vectoring for atan2
    for (genvar g = 0; g < N; g++) begin : g_vec2
        localparam gcd_pkg::t_z ATN = ZW'(gcd_pkg::atan_entry(g));
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (!r_wy[g][XW-1] && (r_wy[g] != '0)) begin
                    r_wx[g+1] <= r_wx[g] + (r_wy[g] >>> g);
                    r_wy[g+1] <= r_wy[g] - (r_wx[g] >>> g);
                    r_wz[g+1] <= r_wz[g] + ATN;
                end else begin
                    r_wx[g+1] <= r_wx[g] - (r_wy[g] >>> g);
                    r_wy[g+1] <= r_wy[g] + (r_wx[g] >>> g);
                    r_wz[g+1] <= r_wz[g] - ATN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_wz[N][ZW-1]) begin
                r_ang_cl <= '0;
            end else if (r_wz[N] > gcd_pkg::HALF_Z) begin
                r_ang_cl <= 32'h8000_0000;
            end else begin
                r_ang_cl <= r_wz[N][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod_a <= r_ang_cl * r_radius;
            r_ang_d1 <= r_ang_cl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p00    <= r_prod_a[31:0] * B_LO;
            r_p01    <= r_prod_a[31:0] * B_HI;
            r_p10    <= r_prod_a[55:32] * B_LO;
            r_p11    <= r_prod_a[55:32] * B_HI;
            r_ang_d2 <= r_ang_d1;
        end
    end

    assign w_sum = (120'(r_p11) << 64) + (120'(r_p01) << 32) + (120'(r_p10) << 32)
                 + 120'(r_p00) + RND_D;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dist    <= w_sum[117:92];
            r_ang_out <= r_ang_d2;
        end
    end

endmodule

// ===== design/gcd_checker.sv =====
// port-level checks for the great circle distance pipeline, bound to the top level
module gcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [25:0] o_distance_m,
    input logic [31:0] o_central_angle
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped while stalled");

    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_distance_m) && $stable(o_central_angle))
        else $error("output payload changed while stalled");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_central_angle <= 32'h8000_0000)
        else $error("central angle above half turn");

    a_dist_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance_m <= 26'd52707179)
        else $error("distance above half circumference of largest sphere");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_distance_m   (o_distance_m),
    .o_central_angle(o_central_angle)
);

// ===== sim/tb_great_circle_distance.sv =====
// testbench for the great circle distance pipeline with a bit-exact fixed-point predictor
module tb_great_circle_distance;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITERS       = gcd_pkg::CORDIC_ITERATIONS;
    localparam int PIPE_CYCLES = 3 * ITERS + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint GAIN    = 64'sd652032874;
    localparam logic [31:0] LAT_N = 32'h4000_0000;
    localparam logic [23:0] RADIUS_EARTH = gcd_pkg::RADIUS_RESET;

    typedef struct {
        logic [25:0] dist_m;
        logic [31:0] angle;
    } t_leg;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_lat_a = '0;
    logic signed [31:0] i_lon_a = '0;
    logic signed [31:0] i_lat_b = '0;
    logic signed [31:0] i_lon_b = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [25:0]        o_distance_m;
    logic [31:0]        o_central_angle;
    logic               i_cfg_we = 1'b0;
    logic [23:0]        i_cfg_wdata = '0;

    longint unsigned atan_lut [ITERS];
    longint unsigned pi4;
    logic [23:0]     radius = RADIUS_EARTH;
    t_leg            legs_due [$];
    int              mismatches = 0;
    int              cycles = 0;
    bit              steady = 1'b0;

    great_circle_distance u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_lat_a         (i_lat_a),
        .i_lon_a         (i_lon_a),
        .i_lat_b         (i_lat_b),
        .i_lon_b         (i_lon_b),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_distance_m    (o_distance_m),
        .o_central_angle (o_central_angle),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned atan_sum(longint unsigned p0, int sq_shift,
                                                 longint unsigned sq_div);
        longint unsigned p;
        longint unsigned acc;
        longint unsigned k;
        p = p0;
        acc = 0;
        k = 0;
        while (p != 0) begin
            if (k[0] == 1'b0) acc = acc + p / (2 * k + 1);
            else acc = acc - p / (2 * k + 1);
            if (sq_div != 0) p = p / sq_div;
            else p = (sq_shift >= 64) ? 0 : (p >> sq_shift);
            k++;
        end
        return acc;
    endfunction

    function automatic void build_tables();
        longint unsigned r;
        longint unsigned q;
        pi4 = 4 * atan_sum((64'd1 << 62) / 5, 0, 25)
            - atan_sum((64'd1 << 62) / 239, 0, 239 * 239);
        atan_lut[0] = 64'd1 << 29;
        for (int i = 1; i < ITERS; i++) begin
            r = atan_sum(64'd1 << (62 - i), 2 * i, 0);
            q = 0;
            for (int j = 0; j < 29; j++) begin
                r = r << 1;
                q = q << 1;
                if (r >= pi4) begin
                    r = r - pi4;
                    q = q | 1;
                end
            end
            r = r << 1;
            if (r >= pi4) q++;
            atan_lut[i] = q;
        end
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void rotate(logic [31:0] ang, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        bit     flip;
        z = longint'($signed(ang));
        x = GAIN;
        y = 0;
        flip = 1'b0;
        if (z > (64'sd1 <<< 30)) begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            if (z >= 0) begin
                y = y + (x >>> i);
                x = x - dx;
                z = z - longint'(atan_lut[i]);
            end else begin
                y = y - (x >>> i);
                x = x + dx;
                z = z + longint'(atan_lut[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint vectorize(longint x, longint y, longint z, output longint xo);
        longint dx;
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            if (y > 0) begin
                y = y - (x >>> i);
                x = x + dx;
                z = z + longint'(atan_lut[i]);
            end else begin
                y = y + (x >>> i);
                x = x - dx;
                z = z - longint'(atan_lut[i]);
            end
        end
        xo = x;
        return z;
    endfunction

    function automatic logic [31:0] pole_clamp(logic signed [31:0] v);
        if (v > $signed(LAT_N)) return LAT_N;
        if (v < -$signed(LAT_N)) return -LAT_N;
        return v;
    endfunction

    function automatic t_leg predict_leg(logic [31:0] la, logic [31:0] lo, logic [31:0] lb,
                                         logic [31:0] lob, logic [23:0] rad);
        longint       s1, c1, s2, c2, sd, cd, y1, y2, b, mx, m, z, unused;
        logic [31:0]  dlon;
        logic [127:0] prod;
        logic [63:0]  hi;
        t_leg         leg;
        rotate(pole_clamp(la), s1, c1);
        rotate(pole_clamp(lb), s2, c2);
        dlon = lob - lo;
        rotate(dlon, sd, cd);
        y1 = qmul(c2, sd);
        y2 = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
        b = qmul(s1, s2) + qmul(qmul(c1, c2), cd);
        if (y1 < 0) y1 = -y1;
        if (y2 < 0) y2 = -y2;
        void'(vectorize(y1, y2, 0, mx));
        m = qmul(mx, GAIN);
        if (m < 0) m = 0;
        if (b < 0) z = vectorize(m, -b, 64'sd1 <<< 30, unused);
        else z = vectorize(b, m, 0, unused);
        if (z < 0) z = 0;
        if (z > (64'sd1 <<< 31)) z = 64'sd1 <<< 31;
        prod = 128'(z) * 128'(rad) * 128'(2 * pi4);
        hi = prod[127:64] + (64'd1 << 27);
        leg.dist_m = hi[53:28];
        leg.angle = z[31:0];
        return leg;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_great_circle_distance: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= !steady && ($urandom_range(99) < 33);
    end

    // result checker
    always @(posedge i_clk) begin
        t_leg want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (legs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: dist %0d angle %0d",
                             o_distance_m, o_central_angle);
            end else begin
                want = legs_due.pop_front();
                if (o_distance_m !== want.dist_m || o_central_angle !== want.angle) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: dist exp %0d got %0d, angle exp %0d got %0d",
                                 want.dist_m, o_distance_m, want.angle, o_central_angle);
                end
            end
        end
    end

    task automatic send_leg(logic [31:0] la, logic [31:0] lo, logic [31:0] lb,
                            logic [31:0] lob);
        if (!steady) begin
            while ($urandom_range(99) < 33) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_lat_a <= la;
        i_lon_a <= lo;
        i_lat_b <= lb;
        i_lon_b <= lob;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        legs_due.push_back(predict_leg(la, lo, lb, lob, radius));
    endtask

    task automatic set_radius(logic [23:0] r);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (legs_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        radius = r;
    endtask

    function automatic logic [31:0] rand_lat();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(32'h8000_0000) - LAT_N;
    endfunction

    task automatic test_directed();
        send_leg(0, 0, 0, 0);
        send_leg(LAT_N, 0, -LAT_N, 0);
        send_leg(LAT_N, 32'h1234_5678, LAT_N, 32'h8765_4321);
        send_leg(-LAT_N, 0, -LAT_N, 32'h8000_0000);
        send_leg(0, 0, 0, 32'h8000_0000);
        send_leg(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        send_leg(0, 32'h7FFF_FFFF, 0, 32'h8000_0000);
        send_leg(32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
        send_leg(32'h4000_0001, 32'hFFFF_FFFF, 32'hBFFF_FFFF, 1);
        send_leg(32'h2000_0000, 32'h4000_0000, 32'hE000_0000, 32'hC000_0000);
        send_leg(32'h1555_5555, 0, 32'h1555_5556, 1);
        send_leg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_leg(32'h3FFF_FFFF, 0, 32'hC000_0001, 32'h8000_0000);
        send_leg(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
        send_leg(32'h0AAA_AAAA, 32'h5555_5555, 32'hF555_5556, 32'hAAAA_AAAA);
    endtask

    task automatic test_radius_settings();
        logic [23:0] settings [5] = '{24'd0, 24'd1, 24'hFF_FFFF, 24'd6378137, RADIUS_EARTH};
        foreach (settings[n]) begin
            set_radius(settings[n]);
            send_leg(0, 0, 0, 32'h8000_0000);
            send_leg(LAT_N, 0, 0, 0);
            send_leg(rand_lat(), $urandom, rand_lat(), $urandom);
            send_leg(0, 0, 0, 1);
        end
    endtask

    task automatic test_random(int count);
        logic [31:0] la, lo, lb, lob;
        for (int n = 0; n < count; n++) begin
            steady = (n >= count / 3) && (n < count / 3 + 120);
            la = rand_lat();
            lo = $urandom;
            case ($urandom_range(3))
                0: begin
                    lb = la + $urandom_range(2047) - 1024;
                    lob = lo + $urandom_range(2047) - 1024;
                end
                1: begin
                    lb = -la + $urandom_range(255) - 128;
                    lob = lo + 32'h8000_0000 + $urandom_range(255) - 128;
                end
                default: begin
                    lb = rand_lat();
                    lob = $urandom;
                end
            endcase
            send_leg(la, lo, lb, lob);
        end
        steady = 1'b0;
    endtask

    initial begin
        build_tables();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_radius_settings();
        test_random(300);
        set_radius(24'h80_0001);
        test_random(300);
        set_radius(RADIUS_EARTH);
        test_random(300);
        i_valid <= 1'b0;
        while (legs_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES + 20) @(posedge i_clk);
        if (mismatches == 0) $display("tb_great_circle_distance: PASS");
        else $display("tb_great_circle_distance: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gcd_pkg.sv
design/great_circle_distance.sv
design/gcd_checker.sv
sim/tb_great_circle_distance.sv
